/* sv/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, datapath command codes and control structs of the running
// sample statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 21;
    localparam int SUM_W    = 37;
    localparam int SQ_W     = 51;
    localparam int MAG_W    = SUM_W - 1;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int FRAC_W   = 8;
    localparam int DVS_W    = 2 * (CNT_W - 1) + 1;
    localparam int REM_W    = DVS_W + 1;
    localparam int DVD_W    = PROD_W + 2 * FRAC_W;
    localparam int QUO_W    = 48;
    localparam int ROOT_W   = QUO_W / 2;
    localparam int MEAN_W   = 24;
    localparam int DEV_W    = 24;
    localparam int STEP_W   = 7;

    // iteration counts of the shared multi-cycle units
    localparam int MUL_CNT_STEPS = CNT_W;
    localparam int MUL_MAG_STEPS = MAG_W;
    localparam int DIV_STEPS     = DVD_W;
    localparam int SQRT_STEPS    = ROOT_W;

    // datapath operations
    localparam logic [3:0] OP_IDLE     = 4'd0;
    localparam logic [3:0] OP_LD_M1    = 4'd1;
    localparam logic [3:0] OP_LD_M2    = 4'd2;
    localparam logic [3:0] OP_LD_M3    = 4'd3;
    localparam logic [3:0] OP_MUL      = 4'd4;
    localparam logic [3:0] OP_LD_DDEV  = 4'd5;
    localparam logic [3:0] OP_DIV      = 4'd6;
    localparam logic [3:0] OP_LD_SQRT  = 4'd7;
    localparam logic [3:0] OP_SQRT     = 4'd8;
    localparam logic [3:0] OP_LD_DMEAN = 4'd9;
    localparam logic [3:0] OP_FINISH   = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic       take;   // accumulate the sample beat on the input
    } t_rss_cmd;

    typedef struct packed {
        logic out_free;
    } t_rss_sts;

endpackage

`default_nettype wire

/* sv/rss_ifs.sv */
// ----------------------------------------------------------------------------
// rss_ifs
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rss_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;
    logic               sample_missing;
    logic               last_sample;

    modport source (output valid, sample_value, sample_missing, last_sample, input ready);
    modport sink   (input valid, sample_value, sample_missing, last_sample, output ready);
endinterface

interface rss_result_if;
    logic               valid;
    logic               ready;
    logic        [20:0] valid_count;
    logic signed [15:0] lowest_value;
    logic signed [15:0] highest_value;
    logic signed [23:0] mean_value;
    logic        [23:0] std_deviation;
    logic               mean_ok;
    logic               deviation_ok;
    logic               count_overflow;

    modport source (output valid, valid_count, lowest_value, highest_value, mean_value,
                    std_deviation, mean_ok, deviation_ok, count_overflow, input ready);
    modport sink   (input valid, valid_count, lowest_value, highest_value, mean_value,
                    std_deviation, mean_ok, deviation_ok, count_overflow, output ready);
endinterface

`default_nettype wire

/* sv/rss_ctrl.sv */
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer: accepts sample beats, then walks the datapath through the
// multiplies, the deviation divide, the square root and the mean divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_last,
    output logic               o_in_ready,
    input  rss_pkg::t_rss_sts  i_sts,
    output rss_pkg::t_rss_cmd  o_cmd
);
    import rss_pkg::*;

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_M1L   = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2L   = 4'd3;
    localparam logic [3:0] S_M2    = 4'd4;
    localparam logic [3:0] S_M3L   = 4'd5;
    localparam logic [3:0] S_M3    = 4'd6;
    localparam logic [3:0] S_D1L   = 4'd7;
    localparam logic [3:0] S_D1    = 4'd8;
    localparam logic [3:0] S_SQL   = 4'd9;
    localparam logic [3:0] S_SQ    = 4'd10;
    localparam logic [3:0] S_D2L   = 4'd11;
    localparam logic [3:0] S_D2    = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_take;
    logic              w_done;

    assign o_in_ready = (r_state == S_ACC);
    assign w_take     = i_in_valid && o_in_ready;
    assign w_done     = (r_step == '0);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd.op    = OP_IDLE;
        o_cmd.take  = w_take;
        unique case (r_state)
            S_ACC: begin
                if (w_take && i_in_last) begin
                    n_state = S_M1L;
                end
            end
            S_M1L: begin
                o_cmd.op = OP_LD_M1;
                n_step   = STEP_W'(MUL_CNT_STEPS - 1);
                n_state  = S_M1;
            end
            S_M1: begin
                o_cmd.op = OP_MUL;
                n_step   = r_step - 1'b1;
                if (w_done) n_state = S_M2L;
            end
            S_M2L: begin
                o_cmd.op = OP_LD_M2;
                n_step   = STEP_W'(MUL_MAG_STEPS - 1);
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_MUL;
                n_step   = r_step - 1'b1;
                if (w_done) n_state = S_M3L;
            end
            S_M3L: begin
                o_cmd.op = OP_LD_M3;
                n_step   = STEP_W'(MUL_CNT_STEPS - 1);
                n_state  = S_M3;
            end
            S_M3: begin
                o_cmd.op = OP_MUL;
                n_step   = r_step - 1'b1;
                if (w_done) n_state = S_D1L;
            end
            S_D1L: begin
                o_cmd.op = OP_LD_DDEV;
                n_step   = STEP_W'(DIV_STEPS - 1);
                n_state  = S_D1;
            end
            S_D1: begin
                o_cmd.op = OP_DIV;
                n_step   = r_step - 1'b1;
                if (w_done) n_state = S_SQL;
            end
            S_SQL: begin
                o_cmd.op = OP_LD_SQRT;
                n_step   = STEP_W'(SQRT_STEPS - 1);
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQRT;
                n_step   = r_step - 1'b1;
                if (w_done) n_state = S_D2L;
            end
            S_D2L: begin
                o_cmd.op = OP_LD_DMEAN;
                n_step   = STEP_W'(DIV_STEPS - 1);
                n_state  = S_D2;
            end
            S_D2: begin
                o_cmd.op = OP_DIV;
                n_step   = r_step - 1'b1;
                if (w_done) n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the result register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

/* sv/rss_dp.sv */
// ----------------------------------------------------------------------------
// rss_dp
// Accumulators, shared shift-add multiplier, restoring divider, bit-pair
// square root and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rss_pkg::t_rss_cmd i_cmd,
    output rss_pkg::t_rss_sts o_sts,
    rss_sample_if.sink        i_smp,
    rss_result_if.source      o_res
);
    import rss_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] LOW_INIT  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] HIGH_INIT = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] MEAN_POS_MAX = QUO_W'((64'd1 << (MEAN_W - 1)) - 1);
    localparam logic [QUO_W-1:0] MEAN_NEG_MAG = QUO_W'(64'd1 << (MEAN_W - 1));

    // statistics
    logic        [CNT_W-1:0]    r_cnt;
    logic signed [SUM_W-1:0]    r_sum;
    logic        [SQ_W-1:0]     r_sq;
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic                       r_ovf;

    // compute registers
    logic [PROD_W-1:0] r_acc, r_mcand, r_p1, r_num;
    logic [MAG_W-1:0]  r_mplier;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [QUO_W-1:0]  r_sx, r_root, r_bit;

    // result register
    logic                      r_ovalid;
    logic [CNT_W-1:0]          r_ocnt;
    logic signed [SAMPLE_W-1:0] r_olo, r_ohi;
    logic [MEAN_W-1:0]         r_omean;
    logic [DEV_W-1:0]          r_odev;
    logic                      r_omok, r_odok, r_oovf;

    logic signed [2*SAMPLE_W-1:0] w_sqr;
    logic [SUM_W-1:0]             w_abs;
    logic [MAG_W-1:0]             w_smag;
    logic [REM_W-1:0]             w_trial;
    logic [QUO_W-1:0]             w_rb;
    logic [MAG_W+FRAC_W:0]        w_mean_x;
    logic [MEAN_W-1:0]            w_mean;
    logic                         w_neg;
    logic                         w_cnt_full;
    logic                         w_has1, w_has2;

    assign w_sqr      = i_smp.sample_value * i_smp.sample_value;
    assign w_neg      = r_sum[SUM_W-1];
    assign w_abs      = w_neg ? (~r_sum + 1'b1) : r_sum;
    assign w_smag     = w_abs[MAG_W-1:0];
    assign w_trial    = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
    assign w_rb       = r_root + r_bit;
    assign w_cnt_full = r_cnt[CNT_W-1];
    assign w_has1     = (r_cnt != '0);
    assign w_has2     = (r_cnt[CNT_W-1:1] != '0);
    // bias by n-1 so the divide rounds negative means toward minus infinity
    assign w_mean_x   = {1'b0, w_smag, {FRAC_W{1'b0}}}
                      + (w_neg ? (MAG_W+FRAC_W+1)'(r_cnt - 1'b1) : '0);

    always_comb begin
        if (!w_neg) begin
            w_mean = (r_quo > MEAN_POS_MAX) ? MEAN_W'(MEAN_POS_MAX) : r_quo[MEAN_W-1:0];
        end else if (r_quo > MEAN_NEG_MAG) begin
            w_mean = MEAN_W'(MEAN_NEG_MAG);
        end else begin
            w_mean = ~r_quo[MEAN_W-1:0] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_lo  <= LOW_INIT;
            r_hi  <= HIGH_INIT;
            r_ovf <= 1'b0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_lo  <= LOW_INIT;
            r_hi  <= HIGH_INIT;
            r_ovf <= 1'b0;
        end else if (i_cmd.take && !i_smp.sample_missing) begin
            if (w_cnt_full) begin
                r_ovf <= 1'b1;      // drop the sample
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= r_sum + SUM_W'(i_smp.sample_value);
                r_sq  <= r_sq + SQ_W'(unsigned'(w_sqr));
                if (i_smp.sample_value < r_lo) r_lo <= i_smp.sample_value;
                if (i_smp.sample_value > r_hi) r_hi <= i_smp.sample_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LD_M1: begin
                r_acc    <= '0;
                r_mcand  <= PROD_W'(r_sq);
                r_mplier <= MAG_W'(r_cnt);
            end
            OP_LD_M2: begin
                r_p1     <= r_acc;
                r_acc    <= '0;
                r_mcand  <= PROD_W'(w_smag);
                r_mplier <= w_smag;
            end
            OP_LD_M3: begin
                r_num    <= r_p1 - r_acc;
                r_acc    <= '0;
                r_mcand  <= PROD_W'(r_cnt);
                r_mplier <= MAG_W'(r_cnt - 1'b1);
            end
            OP_MUL: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            OP_LD_DDEV: begin
                r_dvd <= {r_num, {(2*FRAC_W){1'b0}}};
                r_dvs <= r_acc[DVS_W-1:0];
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_DIV: begin
                r_dvd <= r_dvd << 1;
                if (w_trial >= REM_W'(r_dvs)) begin
                    r_rem <= w_trial - REM_W'(r_dvs);
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
            end
            OP_LD_SQRT: begin
                r_sx   <= r_quo;
                r_root <= '0;
                r_bit  <= QUO_W'(1) << (QUO_W - 2);
            end
            OP_SQRT: begin
                if (r_sx >= w_rb) begin
                    r_sx   <= r_sx - w_rb;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_LD_DMEAN: begin
                r_dvd <= DVD_W'(w_mean_x);
                r_dvs <= DVS_W'(r_cnt);
                r_rem <= '0;
                r_quo <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            r_ocnt  <= r_cnt;
            r_olo   <= w_has1 ? r_lo : '0;
            r_ohi   <= w_has1 ? r_hi : '0;
            r_omean <= w_has1 ? w_mean : '0;
            r_odev  <= w_has2 ? r_root[DEV_W-1:0] : '0;
            r_omok  <= w_has1;
            r_odok  <= w_has2;
            r_oovf  <= r_ovf;
        end
    end

    assign o_sts.out_free = !r_ovalid || o_res.ready;

    assign o_res.valid          = r_ovalid;
    assign o_res.valid_count    = r_ocnt;
    assign o_res.lowest_value   = r_olo;
    assign o_res.highest_value  = r_ohi;
    assign o_res.mean_value     = r_omean;
    assign o_res.std_deviation  = r_odev;
    assign o_res.mean_ok        = r_omok;
    assign o_res.deviation_ok   = r_odok;
    assign o_res.count_overflow = r_oovf;

endmodule

`default_nettype wire

/* sv/running_sample_statistics.sv */
// ----------------------------------------------------------------------------
// running_sample_statistics
// Count, min, max, mean and sample standard deviation over data sets.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  i_smp     in   sample_value, sample_missing, last_sample
//  o_res     out  valid_count, lowest/highest_value, mean_value,
//                 std_deviation, mean_ok, deviation_ok, count_overflow
//
//  Sample beats without the last mark are accepted back to back while ready is high.
//  A last beat starts a closing pass: three shift-add multiplies
//  (21, 36, 21 steps), an 88-step divide, a 24-step square root and an
//  88-step divide, each after a load state, then a finish state;
//  i_smp stays low on ready during the pass.
//  The finish state waits while the output register holds an untaken beat;
//  the next set may start once the result is loaded.
//  Reset is synchronous and clears the statistics and the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module running_sample_statistics (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rss_sample_if.sink    i_smp,
    rss_result_if.source  o_res
);
    import rss_pkg::*;

    t_rss_cmd w_cmd;
    t_rss_sts w_sts;
    logic     w_in_ready;

    assign i_smp.ready = w_in_ready;

    rss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_in_last  (i_smp.last_sample),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rss_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_smp   (i_smp),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

/* sv/rss_checker.sv */
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        i_ready,
    input wire [20:0] i_count,
    input wire        i_mean_ok,
    input wire        i_dev_ok,
    input wire [23:0] i_dev
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_count))
        else $error("result beat dropped while stalled");

    a_mean_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_mean_ok == (i_count != 21'd0)))
        else $error("mean_ok disagrees with count");

    a_dev_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_dev_ok == (i_count > 21'd1)))
        else $error("deviation_ok disagrees with count");

    a_dev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_dev_ok |-> (i_dev == 24'd0))
        else $error("deviation given without two samples");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_count   (o_res.valid_count),
    .i_mean_ok (o_res.mean_ok),
    .i_dev_ok  (o_res.deviation_ok),
    .i_dev     (o_res.std_deviation)
);

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for running_sample_statistics: random and directed
// data sets go in, and each result beat is compared with a predicted set of
// count, extremes, mean and sample deviation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import rss_pkg::*;

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  COUNT_BOUND    = 1 << 20;

    typedef struct packed {
        logic signed [15:0] value;
        logic               missing;
        logic               last;
    } t_sample;

    typedef struct packed {
        logic        [20:0] count;
        logic signed [15:0] low;
        logic signed [15:0] high;
        logic signed [23:0] mean;
        logic        [23:0] dev;
        logic               mean_ok;
        logic               dev_ok;
        logic               ovf;
    } t_stats;

    class rss_scoreboard;
        longint          n;
        longint          sum;
        longint unsigned sumsq;
        longint          low;
        longint          high;
        bit              ovf;
        t_stats          pending[$];
        int              errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            n     = 0;
            sum   = 0;
            sumsq = 0;
            low   = 32767;
            high  = -32768;
            ovf   = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int i = 31; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if (t * t <= x) r = t;
            end
            return r;
        endfunction

        function void note_sample(t_sample s);
            t_stats          e;
            longint          v;
            longint          m;
            logic [127:0]    num;
            logic [127:0]    quo;
            longint unsigned root;
            v = s.value;
            if (!s.missing) begin
                if (n >= COUNT_BOUND) begin
                    ovf = 1;
                end else begin
                    if (v > high) high = v;
                    if (v < low) low = v;
                    sum   += v;
                    sumsq += longint'(v * v);
                    n++;
                end
            end
            if (!s.last) return;
            e = '0;
            e.count = 21'(n);
            e.ovf   = ovf;
            if (n >= 1) begin
                if (sum >= 0) m = (sum * 256) / n;
                else          m = -(((-sum) * 256 + n - 1) / n);
                if (m > 8388607)  m = 8388607;
                if (m < -8388608) m = -8388608;
                e.mean    = 24'(m);
                e.low     = 16'(low);
                e.high    = 16'(high);
                e.mean_ok = 1;
            end
            if (n >= 2) begin
                num = 128'(n) * 128'(sumsq) - 128'(sum < 0 ? -sum : sum) ** 2;
                quo = (num << 16) / (128'(n) * 128'(n - 1));
                if (quo[127:64] != 0) begin
                    e.dev = 24'hFFFFFF;
                end else begin
                    root  = int_sqrt(quo[63:0]);
                    e.dev = (root > 64'hFFFFFF) ? 24'hFFFFFF : root[23:0];
                end
                e.dev_ok = 1;
            end
            pending.push_back(e);
            clear();
        endfunction

        function void compare(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_stats got);
            t_stats e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: count %0d", got.count);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("valid_count", e.count, got.count);
            compare("lowest_value", e.low, got.low);
            compare("highest_value", e.high, got.high);
            compare("mean_value", e.mean, got.mean);
            compare("std_deviation", e.dev, got.dev);
            compare("mean_ok", e.mean_ok, got.mean_ok);
            compare("deviation_ok", e.dev_ok, got.dev_ok);
            compare("count_overflow", e.ovf, got.ovf);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rss_sample_if smp();
    rss_result_if res();

    running_sample_statistics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res)
    );

    rss_scoreboard sb;
    t_sample       stim[$];
    int            sent;
    int            results_seen;
    int            quiet_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic push(logic signed [15:0] v, bit miss, bit last);
        t_sample s;
        s.value   = v;
        s.missing = miss;
        s.last    = last;
        stim.push_back(s);
    endtask

    // random set: mostly short, now and then long, values from a random band
    task automatic push_random_set();
        int len;
        int lo;
        int span;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)      len = 0;
        else if (sel < 3)  len = $urandom_range(50, 200);
        else               len = $urandom_range(1, 16);
        span = (sel % 3 == 0) ? 65535 : $urandom_range(0, 300);
        lo   = $urandom_range(0, 65535 - span) - 32768;
        for (int i = 0; i < len; i++)
            push(16'(lo + $urandom_range(0, span)), $urandom_range(0, 9) == 0, 1'b0);
        push(16'(lo + $urandom_range(0, span)), $urandom_range(0, 4) == 0, 1'b1);
    endtask

    task automatic drive_next();
        t_sample s;
        if (stim.size() > 0 && (quiet_cycles > 0 || $urandom_range(0, 99) >= 9)) begin
            s = stim.pop_front();
            smp.valid          <= 1'b1;
            smp.sample_value   <= s.value;
            smp.sample_missing <= s.missing;
            smp.last_sample    <= s.last;
        end else begin
            smp.valid <= 1'b0;
        end
    endtask

    // sample side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                sb.note_sample({smp.sample_value, smp.sample_missing, smp.last_sample});
                sent++;
            end
            if (!smp.valid || smp.ready) drive_next();
        end
    end

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            sb.check_result({res.valid_count, res.lowest_value, res.highest_value,
                             res.mean_value, res.std_deviation, res.mean_ok,
                             res.deviation_ok, res.count_overflow});
            results_seen++;
        end
        res.ready <= (results_seen >= 40 && results_seen < 80) || $urandom_range(0, 99) >= 9;
    end

    // hold a stretch with no sender gaps
    always @(posedge i_clk) begin
        if (sent == 400) quiet_cycles <= 3000;
        else if (quiet_cycles > 0) quiet_cycles <= quiet_cycles - 1;
    end

    int stalled;
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready)) stalled <= 0;
        else stalled <= stalled + 1;
        if (stalled >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        sb           = new();
        sent         = 0;
        results_seen = 0;
        quiet_cycles = 0;
        stalled      = 0;
        i_rst_n      = 1'b0;
        smp.valid          = 1'b0;
        smp.sample_value   = '0;
        smp.sample_missing = 1'b0;
        smp.last_sample    = 1'b0;
        res.ready          = 1'b0;

        // directed sets
        push(16'sd5, 1'b1, 1'b1);                 // empty set
        push(-16'sd1234, 1'b0, 1'b1);             // single sample
        push(16'sh7FFF, 1'b0, 1'b0);              // extremes, widest spread
        push(16'sh8000, 1'b0, 1'b1);
        push(16'sh8000, 1'b0, 1'b0);              // two lowest: zero spread
        push(16'sh8000, 1'b0, 1'b1);
        push(16'sh7FFF, 1'b0, 1'b0);              // two highest
        push(16'sh7FFF, 1'b0, 1'b1);
        push(16'sd3, 1'b0, 1'b0);                 // missing mid and last
        push(16'sh7FFF, 1'b1, 1'b0);
        push(-16'sd7, 1'b0, 1'b0);
        push(16'sh8000, 1'b1, 1'b1);
        push(-16'sd1, 1'b0, 1'b0);                // negative sum rounding
        push(16'sd0, 1'b0, 1'b0);
        push(16'sd0, 1'b0, 1'b1);
        push(16'sd1, 1'b1, 1'b0);                 // missing then single
        push(16'sd0, 1'b0, 1'b1);

        while (stim.size() < 1100) push_random_set();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim.size() > 0 || smp.valid || sb.pending.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* running_sample_statistics.f */
sv/rss_pkg.sv
sv/rss_ifs.sv
sv/rss_ctrl.sv
sv/rss_dp.sv
sv/running_sample_statistics.sv
sv/rss_checker.sv
tb/testbench.sv
